/* rtl/core/ple_pkg.sv */
// Shared types, sizes and codes for the positional list engine.
`default_nettype none

package ple_pkg;

  // List size and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed payload widths.
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CMD_W    = 2;

  // Width for comparing a position against the count, with one spare bit
  // so that position plus one cannot wrap.
  localparam int CMP_W = ((CNT_W > POS_W - 1) ? CNT_W : POS_W - 1) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_FETCH,
    S_REPLY
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/ple_cmd_if.sv */
// Command channel: valid/ready handshake carrying one list operation.
`default_nettype none

interface ple_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [ple_pkg::CMD_W-1:0]          cmd;
  logic signed [ple_pkg::POS_W-1:0]   position;
  logic signed [ple_pkg::VAL_W-1:0]   value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

`default_nettype wire

/* rtl/core/ple_rsp_if.sv */
// Response channel: valid/ready handshake carrying one operation result.
`default_nettype none

interface ple_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ple_pkg::STATUS_W-1:0]       status;
  logic signed [ple_pkg::VAL_W-1:0]   read_value;
  logic [ple_pkg::CNT_W-1:0]          entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/positional_list_engine.sv */
// Top level of the positional list engine: sequencer, count and result register.
//
//   channel  direction  handshake    payload
//   req      in         valid/ready  cmd, position, value
//   rsp      out        valid/ready  status, read_value, entry_count
//
// One beat on req is taken only while the sequencer is idle. Each entry move
// goes through the entry RAM as a read (S_SHIFT_RD) then a write (S_SHIFT_WR).
// An insert shifts, writes its value (S_PUT) and replies; a delete shifts and
// replies; a read fetches (S_FETCH) and replies; a rejected beat just replies.
// Reset (rst, synchronous) clears the count and the result valid; the entry
// RAM is not cleared. A stalled rsp holds the sequencer in its reply state.
`default_nettype none

module positional_list_engine (
  input  wire logic    clk,
  input  wire logic    rst,
  ple_cmd_if.sink      req,
  ple_rsp_if.source    rsp
);

  ple_pkg::state_t state, state_next;

  logic [ple_pkg::CNT_W-1:0]  count, count_next;
  logic                       rsp_valid;
  logic                       rsp_load;
  logic                       accept;

  // Latched command.
  ple_pkg::cmd_t              op_q;
  ple_pkg::status_t           status_q;
  logic [ple_pkg::IDX_W-1:0]  pos_q;
  logic [ple_pkg::VAL_W-1:0]  val_q;
  logic [ple_pkg::IDX_W-1:0]  idx, idx_step, idx_start;

  // Result register.
  logic [ple_pkg::STATUS_W-1:0] out_status;
  logic [ple_pkg::VAL_W-1:0]    out_value;
  logic [ple_pkg::CNT_W-1:0]    out_count;

  // RAM port controls.
  logic                       ram_we, ram_re;
  logic [ple_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ple_pkg::VAL_W-1:0]  ram_wdata, ram_rdata;

  // Decode of the incoming beat.
  ple_pkg::cmd_t              cmd_in;
  ple_pkg::status_t           status_start;
  logic                       neg;
  logic                       full;
  logic [ple_pkg::CMP_W-1:0]  pos_ext, cnt_ext;

  ple_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready       = (state == ple_pkg::S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_value;
  assign rsp.entry_count = out_count;

  // Range and capacity checks against the current count.
  assign cmd_in  = ple_pkg::cmd_t'(req.cmd);
  assign neg     = req.position[ple_pkg::POS_W-1];
  assign pos_ext = ple_pkg::CMP_W'(req.position[ple_pkg::POS_W-2:0]);
  assign cnt_ext = ple_pkg::CMP_W'(count);
  assign full    = (count == ple_pkg::CNT_W'(ple_pkg::CAPACITY));

  always_comb begin
    status_start = ple_pkg::STATUS_RANGE;
    case (cmd_in)
      ple_pkg::CMD_INSERT: begin
        if (!neg && pos_ext <= cnt_ext) begin
          status_start = full ? ple_pkg::STATUS_FULL : ple_pkg::STATUS_DONE;
        end
      end
      ple_pkg::CMD_DELETE, ple_pkg::CMD_READ: begin
        if (!neg && pos_ext < cnt_ext) begin
          status_start = ple_pkg::STATUS_DONE;
        end
      end
      default: status_start = ple_pkg::STATUS_RANGE;
    endcase
  end

  // Insert shifts from the tail downward; delete shifts from the hole upward.
  assign idx_start = (cmd_in == ple_pkg::CMD_INSERT) ? ple_pkg::IDX_W'(count)
                                                     : ple_pkg::IDX_W'(pos_ext);

  // Count after a successful insert or delete.
  always_comb begin
    count_next = count;
    if (status_q == ple_pkg::STATUS_DONE) begin
      if (op_q == ple_pkg::CMD_INSERT) begin
        count_next = count + ple_pkg::CNT_W'(1);
      end else if (op_q == ple_pkg::CMD_DELETE) begin
        count_next = count - ple_pkg::CNT_W'(1);
      end
    end
  end

  // Sequencer next state and RAM controls.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = idx;
    ram_raddr  = idx;
    ram_wdata  = val_q;
    idx_step   = idx;
    rsp_load   = 1'b0;
    case (state)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          if (status_start != ple_pkg::STATUS_DONE) begin
            state_next = ple_pkg::S_REPLY;
          end else begin
            case (cmd_in)
              ple_pkg::CMD_INSERT: begin
                state_next = (cnt_ext > pos_ext) ? ple_pkg::S_SHIFT_RD : ple_pkg::S_PUT;
              end
              ple_pkg::CMD_DELETE: begin
                state_next = (cnt_ext > pos_ext + ple_pkg::CMP_W'(1)) ? ple_pkg::S_SHIFT_RD
                                                                      : ple_pkg::S_REPLY;
              end
              ple_pkg::CMD_READ: state_next = ple_pkg::S_FETCH;
              default:           state_next = ple_pkg::S_REPLY;
            endcase
          end
        end
      end
      ple_pkg::S_SHIFT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = (op_q == ple_pkg::CMD_INSERT) ? idx - ple_pkg::IDX_W'(1)
                                                   : idx + ple_pkg::IDX_W'(1);
        state_next = ple_pkg::S_SHIFT_WR;
      end
      ple_pkg::S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if (op_q == ple_pkg::CMD_INSERT) begin
          idx_step   = idx - ple_pkg::IDX_W'(1);
          state_next = (idx_step == pos_q) ? ple_pkg::S_PUT : ple_pkg::S_SHIFT_RD;
        end else begin
          idx_step   = idx + ple_pkg::IDX_W'(1);
          state_next = (ple_pkg::CNT_W'(idx) + ple_pkg::CNT_W'(2) == count)
                       ? ple_pkg::S_REPLY : ple_pkg::S_SHIFT_RD;
        end
      end
      ple_pkg::S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_q;
        ram_wdata  = val_q;
        state_next = ple_pkg::S_REPLY;
      end
      ple_pkg::S_FETCH: begin
        ram_re     = 1'b1;
        ram_raddr  = pos_q;
        state_next = ple_pkg::S_REPLY;
      end
      ple_pkg::S_REPLY: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ple_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Command latch, shift index and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= cmd_in;
      status_q <= status_start;
      pos_q    <= ple_pkg::IDX_W'(pos_ext);
      val_q    <= req.value;
      idx      <= idx_start;
    end else if (state == ple_pkg::S_SHIFT_WR) begin
      idx <= idx_step;
    end
    if (rsp_load) begin
      out_status <= status_q;
      out_value  <= (op_q == ple_pkg::CMD_READ && status_q == ple_pkg::STATUS_DONE)
                    ? ram_rdata : '0;
      out_count  <= count_next;
    end
  end

  // The count never exceeds the list capacity.
  assert property (@(posedge clk) disable iff (rst)
    count <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("entry count above capacity");

  // An accepted beat always leaves the sequencer busy for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("sequencer ready right after accepting a beat");

  // A successful insert raises the count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    rsp_load && op_q == ple_pkg::CMD_INSERT && status_q == ple_pkg::STATUS_DONE
    |=> count == $past(count) + ple_pkg::CNT_W'(1))
    else $error("insert did not advance the count");

  // A rejected beat never writes the entry RAM.
  assert property (@(posedge clk) disable iff (rst)
    ram_we && state != ple_pkg::S_IDLE |-> status_q == ple_pkg::STATUS_DONE)
    else $error("RAM written for a rejected command");

  // Loading a result always returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> state == ple_pkg::S_IDLE)
    else $error("sequencer not idle after loading a result");

endmodule

`default_nettype wire

/* rtl/core/ple_ram.sv */
// Entry storage: one write port and one read port with registered read data.
`default_nettype none

module ple_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ple_pkg::IDX_W-1:0]   waddr,
  input  wire logic [ple_pkg::VAL_W-1:0]   wdata,
  input  wire logic                        re,
  input  wire logic [ple_pkg::IDX_W-1:0]   raddr,
  output logic      [ple_pkg::VAL_W-1:0]   rdata
);

  logic [ple_pkg::VAL_W-1:0] mem [ple_pkg::CAPACITY];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the positional list engine: mirrored list, random traffic, per-beat checks.

module tb_top;

  // Command code outside the defined set, which the engine must reject.
  localparam logic [ple_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Longest stretch with no beat on either channel before the run is called hung.
  localparam int HANG_LIMIT = 2000;
  // Quiet time after the last reply, longer than the slowest insert.
  localparam int SETTLE_CYCLES = 2 * ple_pkg::CAPACITY + 20;

  typedef struct packed {
    ple_pkg::status_t                  status;
    logic signed [ple_pkg::VAL_W-1:0]  read_value;
    logic [ple_pkg::CNT_W-1:0]         entry_count;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ple_cmd_if req ();
  ple_rsp_if rsp ();

  positional_list_engine u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Mirror of the list contents and the replies still owed by the engine.
  logic signed [ple_pkg::VAL_W-1:0] list_mirror [ple_pkg::CAPACITY];
  int                               mirror_count = 0;
  list_reply_t                      due_replies [$];

  int error_count = 0;
  int beat_count = 0;
  int burst_left = 0;
  int insert_tally = 0;
  int delete_tally = 0;
  int read_tally = 0;
  int range_tally = 0;
  int full_tally = 0;
  int peak_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the mirror and returns the reply it must produce.
  function automatic list_reply_t apply_to_mirror(
      input logic [ple_pkg::CMD_W-1:0]        c,
      input logic signed [ple_pkg::POS_W-1:0] pos,
      input logic signed [ple_pkg::VAL_W-1:0] val);
    list_reply_t r;
    int p;
    p = pos;
    r.status = ple_pkg::STATUS_RANGE;
    r.read_value = '0;
    case (c)
      ple_pkg::CMD_INSERT: begin
        if (p >= 0 && p <= mirror_count) begin
          if (mirror_count >= ple_pkg::CAPACITY) begin
            r.status = ple_pkg::STATUS_FULL;
          end else begin
            for (int i = mirror_count; i > p; i--) list_mirror[i] = list_mirror[i - 1];
            list_mirror[p] = val;
            mirror_count++;
            r.status = ple_pkg::STATUS_DONE;
            insert_tally++;
          end
        end
      end
      ple_pkg::CMD_DELETE: begin
        if (p >= 0 && p < mirror_count) begin
          for (int i = p; i < mirror_count - 1; i++) list_mirror[i] = list_mirror[i + 1];
          mirror_count--;
          r.status = ple_pkg::STATUS_DONE;
          delete_tally++;
        end
      end
      ple_pkg::CMD_READ: begin
        if (p >= 0 && p < mirror_count) begin
          r.read_value = list_mirror[p];
          r.status = ple_pkg::STATUS_DONE;
          read_tally++;
        end
      end
      default: begin
      end
    endcase
    if (r.status == ple_pkg::STATUS_RANGE) range_tally++;
    if (r.status == ple_pkg::STATUS_FULL) full_tally++;
    if (mirror_count > peak_count) peak_count = mirror_count;
    r.entry_count = mirror_count[ple_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ple_pkg::POS_W-1:0] to_pos(input int p);
    return p[ple_pkg::POS_W-1:0];
  endfunction

  // Mostly random words, with the extremes mixed in.
  function automatic logic signed [ple_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(ple_pkg::VAL_W-1){1'b1}}};
      1: return {1'b1, {(ple_pkg::VAL_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Sends one command beat; the sender works in bursts separated by random gaps.
  task automatic send_beat(input logic [ple_pkg::CMD_W-1:0] c,
                           input logic signed [ple_pkg::POS_W-1:0] pos,
                           input logic signed [ple_pkg::VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid    <= 1'b1;
    req.cmd      <= c;
    req.position <= pos;
    req.value    <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    due_replies.push_back(apply_to_mirror(c, pos, val));
    beat_count++;
  endtask

  // Holds the sender off until the engine has answered everything.
  task automatic wait_for_replies();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_replies.size() != 0);
  endtask

  // Edge cases on an empty and a short list, every command and the unused code.
  task automatic test_directed_cases();
    send_beat(ple_pkg::CMD_READ, to_pos(0), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(0), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(1), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(-1), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(-128), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(0), {1'b0, {(ple_pkg::VAL_W-1){1'b1}}});
    send_beat(ple_pkg::CMD_INSERT, to_pos(1), {1'b1, {(ple_pkg::VAL_W-1){1'b0}}});
    send_beat(ple_pkg::CMD_INSERT, to_pos(0), '1);
    send_beat(ple_pkg::CMD_INSERT, to_pos(1), '0);
    send_beat(ple_pkg::CMD_INSERT, to_pos(2), 32'sh5555_5555);
    for (int i = 0; i < 5; i++) send_beat(ple_pkg::CMD_READ, to_pos(i), pick_value());
    send_beat(ple_pkg::CMD_READ, to_pos(5), pick_value());
    send_beat(ple_pkg::CMD_READ, to_pos(127), pick_value());
    send_beat(ple_pkg::CMD_READ, to_pos(-1), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(5), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(2), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(3), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(0), pick_value());
    send_beat(CMD_UNUSED, to_pos(0), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(127), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(-128), pick_value());
  endtask

  // Fills the list to capacity, probes the full case, then empties it again.
  task automatic test_full_list();
    while (mirror_count < ple_pkg::CAPACITY) begin
      send_beat(ple_pkg::CMD_INSERT, to_pos($urandom_range(0, mirror_count)), pick_value());
    end
    send_beat(ple_pkg::CMD_INSERT, to_pos(0), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(ple_pkg::CAPACITY), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(ple_pkg::CAPACITY + 1), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(-1), pick_value());
    send_beat(ple_pkg::CMD_READ, to_pos(ple_pkg::CAPACITY - 1), pick_value());
    send_beat(ple_pkg::CMD_READ, to_pos(ple_pkg::CAPACITY), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(ple_pkg::CAPACITY), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(0), pick_value());
    send_beat(ple_pkg::CMD_INSERT, to_pos(ple_pkg::CAPACITY - 1), pick_value());
    send_beat(ple_pkg::CMD_DELETE, to_pos(ple_pkg::CAPACITY - 1), pick_value());
    while (mirror_count > 0) begin
      if ($urandom_range(0, 2) == 0) begin
        send_beat(ple_pkg::CMD_READ, to_pos($urandom_range(0, mirror_count - 1)),
                  pick_value());
      end
      send_beat(ple_pkg::CMD_DELETE, to_pos($urandom_range(0, mirror_count - 1)),
                pick_value());
    end
    send_beat(ple_pkg::CMD_DELETE, to_pos(0), pick_value());
    send_beat(ple_pkg::CMD_READ, to_pos(0), pick_value());
  endtask

  // Random traffic that steers the list length toward moving targets, with
  // some off-by-one positions and some fully random beats as noise.
  task automatic test_random_mix(input int beats);
    int target;
    int roll;
    int pick;
    int ins_pct;
    int p;
    logic [ple_pkg::CMD_W-1:0] c;
    target = $urandom_range(0, ple_pkg::CAPACITY);
    for (int n = 0; n < beats; n++) begin
      if (n == beats / 2) wait_for_replies();
      if (mirror_count == target) target = $urandom_range(0, ple_pkg::CAPACITY);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        pick = $urandom_range(0, 15);
        c = (pick == 0) ? CMD_UNUSED : (pick < 6) ? ple_pkg::CMD_INSERT :
            (pick < 11) ? ple_pkg::CMD_DELETE : ple_pkg::CMD_READ;
        send_beat(c, to_pos($urandom_range(0, 255)), pick_value());
      end else begin
        ins_pct = (mirror_count < target) ? 60 : 25;
        pick = $urandom_range(0, 99);
        if (mirror_count == 0 || pick < ins_pct) begin
          c = ple_pkg::CMD_INSERT;
          p = (roll < 13) ? mirror_count + 1 : $urandom_range(0, mirror_count);
        end else begin
          c = (pick < ins_pct + 25) ? ple_pkg::CMD_READ : ple_pkg::CMD_DELETE;
          p = (roll < 13) ? mirror_count : $urandom_range(0, mirror_count - 1);
        end
        send_beat(c, to_pos(p), pick_value());
      end
    end
  endtask

  // Reply checker and receiver stall pattern.
  int  ready_hold = 0;
  bit  ready_now = 1'b0;

  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_replies.size() == 0) begin
        $display("%0t: reply with none pending: status=%0d read_value=%0d entry_count=%0d",
                 $time, rsp.status, rsp.read_value, rsp.entry_count);
        error_count++;
      end else begin
        want = due_replies.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, rsp.status);
          error_count++;
        end
        if (rsp.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %0d, got %0d",
                   $time, want.read_value, rsp.read_value);
          error_count++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $display("%0t: entry_count mismatch: expected %0d, got %0d",
                   $time, want.entry_count, rsp.entry_count);
          error_count++;
        end
      end
    end
    // Short stalls alternate with runs of ready, some of them long.
    if (ready_hold == 0) begin
      ready_now = !ready_now;
      if (ready_now) begin
        ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      end else begin
        ready_hold = $urandom_range(1, 6);
      end
    end
    ready_hold--;
    rsp.ready <= ready_now;
  end

  // Hang detection: counts cycles with no beat on either channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d replies pending",
               $time, HANG_LIMIT, due_replies.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req.valid    = 1'b0;
    req.cmd      = ple_pkg::CMD_INSERT;
    req.position = '0;
    req.value    = '0;
    rsp.ready    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    wait_for_replies();
    test_full_list();
    wait_for_replies();
    test_random_mix(265);
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d inserts, %0d deletes and %0d reads completed.",
             beat_count, insert_tally, delete_tally, read_tally);
    $display("Rejected %0d for position and %0d for a full list; longest list %0d entries.",
             range_tally, full_tally, peak_count);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* positional_list_engine.f */
rtl/core/ple_pkg.sv
rtl/core/ple_cmd_if.sv
rtl/core/ple_rsp_if.sv
rtl/core/ple_ram.sv
rtl/core/positional_list_engine.sv
test/tb_top.sv
